### sv/mcfh_pkg.sv
// shared types, constants and hash step for the masked-code fnv-1a hasher
package mcfh_pkg;

  // fnv-1a 64 constants
  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

  // opcodes with a 4-byte operand
  localparam logic [7:0] OP_CALL     = 8'hE8;
  localparam logic [7:0] OP_JMP      = 8'hE9;
  localparam logic [7:0] OP_ESC      = 8'h0F;
  localparam logic [7:0] OP_MOV_LO   = 8'hB8;
  localparam logic [7:0] OP_MOV_HI   = 8'hBF;
  localparam logic [7:0] OP_PUSH     = 8'h68;
  localparam logic [3:0] JCC_NIBBLE  = 4'h8;

  // lookahead window
  localparam int         WIN_DEPTH   = 6;
  localparam logic [2:0] WIN_FULL    = 3'd6;
  localparam logic [2:0] IMM_NEED    = 3'd5;
  localparam logic [2:0] JCC_NEED    = 3'd6;
  localparam logic [2:0] JCC_LOOK    = 3'd2;

  // operand skip codes: jcc passes its second opcode byte raw first
  localparam logic [2:0] SKIP_NONE    = 3'd0;
  localparam logic [2:0] SKIP_OPERAND = 3'd4;
  localparam logic [2:0] SKIP_JCC     = 3'd5;

  // prefix hash length in raw bytes
  localparam logic [2:0] PREFIX_LENGTH = 3'd5;

  // queue between scanner and folder
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  // one decided byte on its way to the folder
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [63:0] prefix;
  } q_entry_t;

  // fnv-1a step: xor byte, multiply by 2^40 + 2^8 + 0xb3 as shift-add
  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

### sv/mcfh_in_if.sv
// input channel: one code byte per transfer with end-of-function flag
interface mcfh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       final_byte;

  modport source (output valid, output code_byte, output final_byte, input ready);
  modport sink (input valid, input code_byte, input final_byte, output ready);
endinterface

### sv/mcfh_out_if.sv
// output channel: both hashes of one function per transfer
interface mcfh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] masked_hash;
  logic [63:0] prefix_hash;

  modport source (output valid, output masked_hash, output prefix_hash, input ready);
  modport sink (input valid, input masked_hash, input prefix_hash, output ready);
endinterface

### sv/mcfh_front.sv
// front: lookahead window, opcode scanner, operand masking and prefix hash
module mcfh_front (
  input  logic               clk,
  input  logic               rst,
  mcfh_in_if.sink            code_in,
  output logic               push,
  output mcfh_pkg::q_entry_t push_entry,
  input  logic               q_full
);
  import mcfh_pkg::*;

  logic [7:0]  win [WIN_DEPTH];
  logic [7:0]  win_next [WIN_DEPTH];
  logic [2:0]  fill, fill_next, fill_after_pop;
  logic [2:0]  skip, skip_next;
  logic        end_held, end_held_next;
  logic [63:0] prefix_hash, prefix_hash_next;
  logic [2:0]  prefix_pos, prefix_pos_next;
  logic        decide;
  logic [7:0]  emit_byte;
  logic [2:0]  decide_skip;
  logic        is_imm_op, is_esc, jcc_second;
  logic        accept;
  logic        last_pop;

  // opcode classes at the window head
  assign is_imm_op  = (win[0] == OP_CALL) || (win[0] == OP_JMP) || (win[0] == OP_PUSH) ||
                      ((win[0] >= OP_MOV_LO) && (win[0] <= OP_MOV_HI));
  assign is_esc     = (win[0] == OP_ESC);
  assign jcc_second = (win[1][7:4] == JCC_NIBBLE);

  // scanner decision about the head byte
  always_comb begin
    decide      = 1'b0;
    emit_byte   = win[0];
    decide_skip = SKIP_NONE;
    priority if (fill == 3'd0) begin
      decide = 1'b0;
    end else if (skip != SKIP_NONE) begin
      decide      = 1'b1;
      emit_byte   = (skip == SKIP_JCC) ? win[0] : 8'd0;
      decide_skip = skip - 3'd1;
    end else if (is_imm_op) begin
      if (fill >= IMM_NEED) begin
        decide      = 1'b1;
        decide_skip = SKIP_OPERAND;
      end else begin
        decide = end_held;
      end
    end else if (is_esc) begin
      if (fill < JCC_LOOK) begin
        decide = end_held;
      end else if (!jcc_second) begin
        decide = 1'b1;
      end else if (fill >= JCC_NEED) begin
        decide      = 1'b1;
        decide_skip = SKIP_JCC;
      end else begin
        decide = end_held;
      end
    end else begin
      decide = 1'b1;
    end
  end

  // transfer into the queue and input handshake
  assign push                = decide && !q_full;
  assign last_pop            = push && end_held && (fill == 3'd1);
  assign push_entry.data     = emit_byte;
  assign push_entry.last     = end_held && (fill == 3'd1);
  assign push_entry.prefix   = prefix_hash;
  assign code_in.ready       = !end_held && ((fill < WIN_FULL) || push);
  assign accept              = code_in.valid && code_in.ready;
  assign fill_after_pop      = fill - {2'd0, push};

  // window shift and insert
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (push && (i < WIN_DEPTH - 1)) begin
        win_next[i] = win[i + 1];
      end else if (push) begin
        win_next[i] = 8'd0;
      end else begin
        win_next[i] = win[i];
      end
      if (accept && (fill_after_pop == 3'(i))) begin
        win_next[i] = code_in.code_byte;
      end
    end
    fill_next = accept ? fill_after_pop + 3'd1 : fill_after_pop;
  end

  // skip count, end flag and prefix hash
  always_comb begin
    skip_next        = push ? decide_skip : skip;
    end_held_next    = end_held;
    prefix_hash_next = prefix_hash;
    prefix_pos_next  = prefix_pos;
    if (accept && code_in.final_byte) begin
      end_held_next = 1'b1;
    end
    if (accept && (prefix_pos < PREFIX_LENGTH)) begin
      prefix_hash_next = fnv_fold(prefix_hash, code_in.code_byte);
      prefix_pos_next  = prefix_pos + 3'd1;
    end
    if (last_pop) begin
      skip_next        = SKIP_NONE;
      end_held_next    = 1'b0;
      prefix_hash_next = FNV_BASIS;
      prefix_pos_next  = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= 3'd0;
      skip        <= SKIP_NONE;
      end_held    <= 1'b0;
      prefix_hash <= FNV_BASIS;
      prefix_pos  <= 3'd0;
    end else begin
      fill        <= fill_next;
      skip        <= skip_next;
      end_held    <= end_held_next;
      prefix_hash <= prefix_hash_next;
      prefix_pos  <= prefix_pos_next;
    end
  end

  // operand bytes being zeroed are always already in the window
  a_skip_covered: assert property (@(posedge clk) disable iff (rst)
    (skip != SKIP_NONE) |-> (fill >= skip))
    else $error("operand skip runs past window contents");

  // the end-of-function transfer leaves the front empty
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    last_pop |=> (fill == 3'd0) && !end_held && (prefix_pos == 3'd0))
    else $error("front not cleared after last byte");

  // prefix counter saturates at its length
  a_prefix_sat: assert property (@(posedge clk) disable iff (rst)
    prefix_pos <= PREFIX_LENGTH)
    else $error("prefix position out of range");

endmodule

### sv/mcfh_queue.sv
// short queue of decided bytes between scanner and folder
module mcfh_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mcfh_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output mcfh_pkg::q_entry_t head_entry
);
  import mcfh_pkg::*;

  q_entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr, rd_ptr;
  logic [QUEUE_CW-1:0]   count, count_next;
  logic                  do_pop;

  assign full       = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  // occupancy
  always_comb begin
    count_next = count;
    if (push && !do_pop) begin
      count_next = count + QUEUE_CW'(1);
    end else if (!push && do_pop) begin
      count_next = count - QUEUE_CW'(1);
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      count <= count_next;
    end
  end

  // producer never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

endmodule

### sv/mcfh_back.sv
// back: fnv-1a fold of the masked stream and result register
module mcfh_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  mcfh_pkg::q_entry_t head_entry,
  output logic               pop,
  mcfh_out_if.source         hash_out
);
  import mcfh_pkg::*;

  logic [63:0] hash, hash_folded;
  logic [63:0] masked_reg, prefix_reg;
  logic        out_valid, out_valid_next;
  logic        end_fold;

  // fold one byte per transfer; the end byte waits for a free result slot
  assign hash_folded = fnv_fold(hash, head_entry.data);
  assign pop         = head_valid && (!head_entry.last || !out_valid || hash_out.ready);
  assign end_fold    = pop && head_entry.last;

  assign hash_out.valid       = out_valid;
  assign hash_out.masked_hash = masked_reg;
  assign hash_out.prefix_hash = prefix_reg;

  // result valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (end_fold) begin
      out_valid_next = 1'b1;
    end else if (hash_out.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_fold) begin
      masked_reg <= hash_folded;
      prefix_reg <= head_entry.prefix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash      <= FNV_BASIS;
      out_valid <= 1'b0;
    end else begin
      if (end_fold) begin
        hash <= FNV_BASIS;
      end else if (pop) begin
        hash <= hash_folded;
      end
      out_valid <= out_valid_next;
    end
  end

  // running hash restarts from the basis after each function
  a_hash_restart: assert property (@(posedge clk) disable iff (rst)
    end_fold |=> (hash == FNV_BASIS) && out_valid)
    else $error("hash not restarted after end of function");

endmodule

### sv/masked_code_fnv1a_hash_top.sv
// top level of the masked-code fnv-1a 64 hasher
//
//   port      dir  payload                       transfer
//   code_in   in   code_byte[7:0], final_byte    valid && ready
//   hash_out  out  masked_hash[63:0],            valid && ready
//                  prefix_hash[63:0]
//
// Steady state takes one code byte per cycle while the queue has room; the scanner
// and the fnv fold unit each handle one byte per cycle, with a 4-entry queue between
// them. After the final byte, input holds off while the lookahead window (up to 6
// bytes) drains into the queue at one byte per cycle while the queue has room; the
// next function starts after that. The result is registered as the final byte is
// folded and holds until taken. Reset is synchronous; there is no clearing pass.
module masked_code_fnv1a_hash_top (
  input  logic        clk,
  input  logic        rst,
  mcfh_in_if.sink     code_in,
  mcfh_out_if.source  hash_out
);
  import mcfh_pkg::*;

  logic     push, q_full, pop, head_valid;
  q_entry_t push_entry, head_entry;

  // scanner and prefix hash
  mcfh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .code_in    (code_in),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  // decoupling queue
  mcfh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // masked hash fold and result
  mcfh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .hash_out   (hash_out)
  );

endmodule
